FILE: sv/adc_sample_frame_packer_assert.svh
// Assertion macros for the ADC sample frame packer.
`ifndef ADC_SAMPLE_FRAME_PACKER_ASSERT_SVH
`define ADC_SAMPLE_FRAME_PACKER_ASSERT_SVH

`ifndef SYNTH
// Checked property, skipped while reset is high.
`define ASFP_CHECK(label, clock, reset, prop, msg) \
  label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Checked property, also evaluated during reset.
`define ASFP_CHECK_ALWAYS(label, clock, prop, msg) \
  label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define ASFP_CHECK(label, clock, reset, prop, msg)
`define ASFP_CHECK_ALWAYS(label, clock, prop, msg)
`endif

`endif

FILE: sv/asfp_pkg.sv
// Shared constants and types of the ADC sample frame packer.
`timescale 1ns / 1ps
package asfp_pkg;

  localparam logic [7:0]  TAG_DATA          = 8'h0a;
  localparam logic [7:0]  TAG_COUNT         = 8'h10;
  localparam logic [7:0]  PACK_MAGIC        = 8'ha5;
  localparam logic [13:0] HDR_SIZE          = 14'd4;
  localparam logic [12:0] MAX_FRAME_SAMPLES = 13'd4096;
  localparam logic [4:0]  WIDTH_RESET       = 5'd12;
  localparam logic [4:0]  WIDTH_MAX         = 5'd16;
  localparam int          RUN_MAX           = 13;
  localparam logic [3:0]  RUN_MAX_LEN       = 4'(RUN_MAX);

  // APB register map
  localparam int          ADDR_W            = 3;
  localparam logic [ADDR_W-1:0] ADDR_SAMPLE_WIDTH = 3'd0;

  typedef struct packed {
    logic [7:0]  bit_buf;
    logic [2:0]  bits;
    logic        in_frame;
    logic [12:0] samples_left;
    logic [12:0] frame_count;
    logic [4:0]  frame_width;
  } state_t;

  // Bytes caused by one input transaction
  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] bytes;
    logic [3:0]              len;
    logic                    frame_end;
  } run_t;

endpackage

FILE: sv/asfp_frame_fmt.sv
// Framing and bit packing of one sample: next state and byte run.
`timescale 1ns / 1ps
module asfp_frame_fmt (
  input  logic [4:0]      sample_width,
  input  logic [15:0]     raw_sample,
  input  logic [12:0]     frame_samples,
  input  asfp_pkg::state_t cur,
  output asfp_pkg::state_t nxt,
  output asfp_pkg::run_t   run
);
  import asfp_pkg::*;

  logic        start;
  logic [4:0]  w_cfg;
  logic [12:0] cnt_cfg;
  logic [4:0]  w_use;
  logic [12:0] cnt_use;
  logic [12:0] left;
  logic [12:0] left_n;
  logic [7:0]  buf_in;
  logic [2:0]  bb_in;
  logic [16:0] prod;
  logic [13:0] plen;
  logic [15:0] mask;
  logic [22:0] acc;
  logic [4:0]  bits;
  logic [7:0]  buf_n;
  logic [3:0]  n;

  always_comb begin
    nxt   = cur;
    run   = '0;
    n     = '0;
    start = !cur.in_frame;

    if (sample_width == 5'd0) begin
      w_cfg = 5'd1;
    end else if (sample_width > WIDTH_MAX) begin
      w_cfg = WIDTH_MAX;
    end else begin
      w_cfg = sample_width;
    end
    if (frame_samples == 13'd0) begin
      cnt_cfg = 13'd1;
    end else if (frame_samples > MAX_FRAME_SAMPLES) begin
      cnt_cfg = MAX_FRAME_SAMPLES;
    end else begin
      cnt_cfg = frame_samples;
    end

    if (start) begin
      w_use   = w_cfg;
      cnt_use = cnt_cfg;
      left    = cnt_cfg;
      buf_in  = 8'd0;
      bb_in   = 3'd0;
    end else begin
      w_use   = cur.frame_width;
      cnt_use = cur.frame_count;
      left    = cur.samples_left;
      buf_in  = cur.bit_buf;
      bb_in   = cur.bits;
    end

    prod = 17'(cnt_use) * 17'(w_use);
    plen = HDR_SIZE + 14'((prod + 17'd7) >> 3);

    if (start) begin
      run.bytes[n] = TAG_DATA; n = n + 4'd1;
      if (plen[13:7] != 7'd0) begin
        run.bytes[n] = {1'b1, plen[6:0]}; n = n + 4'd1;
        run.bytes[n] = {1'b0, plen[13:7]}; n = n + 4'd1;
      end else begin
        run.bytes[n] = {1'b0, plen[6:0]}; n = n + 4'd1;
      end
      run.bytes[n] = PACK_MAGIC;           n = n + 4'd1;
      run.bytes[n] = {3'd0, w_use};        n = n + 4'd1;
      run.bytes[n] = cnt_use[7:0];         n = n + 4'd1;
      run.bytes[n] = {3'd0, cnt_use[12:8]}; n = n + 4'd1;
    end

    // LSB-first packing behind the pending bits
    mask = 16'((17'd1 << w_use) - 17'd1);
    acc  = {15'd0, buf_in} | (23'(raw_sample & mask) << bb_in);
    bits = {2'd0, bb_in} + w_use;
    if (bits >= 5'd8) begin
      run.bytes[n] = acc[7:0]; n = n + 4'd1;
    end
    if (bits >= 5'd16) begin
      run.bytes[n] = acc[15:8]; n = n + 4'd1;
    end
    case (bits[4:3])
      2'd1:    buf_n = acc[15:8];
      2'd2:    buf_n = {1'b0, acc[22:16]};
      default: buf_n = acc[7:0];
    endcase

    left_n = left - 13'd1;
    nxt.in_frame     = 1'b1;
    nxt.frame_width  = w_use;
    nxt.frame_count  = cnt_use;
    nxt.samples_left = left_n;
    nxt.bit_buf      = buf_n;
    nxt.bits         = bits[2:0];

    if (left_n == 13'd0) begin
      // last sample: flush, trailer tag and count
      if (bits[2:0] != 3'd0) begin
        run.bytes[n] = buf_n; n = n + 4'd1;
      end
      run.bytes[n] = TAG_COUNT; n = n + 4'd1;
      if (cnt_use[12:7] != 6'd0) begin
        run.bytes[n] = {1'b1, cnt_use[6:0]};  n = n + 4'd1;
        run.bytes[n] = {2'b00, cnt_use[12:7]}; n = n + 4'd1;
      end else begin
        run.bytes[n] = {1'b0, cnt_use[6:0]}; n = n + 4'd1;
      end
      run.frame_end = 1'b1;
      nxt.in_frame  = 1'b0;
      nxt.bit_buf   = 8'd0;
      nxt.bits      = 3'd0;
    end

    run.len = n;
  end

endmodule

FILE: sv/adc_sample_frame_packer.sv
// Top level of the ADC sample frame packer: registers, byte serializer, APB port.
`timescale 1ns / 1ps
`include "adc_sample_frame_packer_assert.svh"
//
//  channel   direction  handshake             payload
//  -------   ---------  --------------------  ----------------------------------
//  in        sink       in_valid / in_stall   raw_sample, frame_samples
//  out       source     out_valid / out_stall out_byte, run_last, frame_end
//  apb       slave      psel/penable/pready   paddr, pwrite, pwdata, prdata
//
//  A sample lands in an input register; combinational framing logic turns
//  it into a run of 0..13 bytes, which drain one byte per cycle through the
//  output register while out_stall is low. A new sample's run loads as
//  the last byte of the previous run moves out, or at once if it is empty.
//  The byte serializer is the limit. Synchronous reset clears all control
//  state; sample_width resets to 12. out_stall holds the output register
//  and backs up into in_stall once the run buffer cannot take a new run.
//
module adc_sample_frame_packer (
  input  logic                        clk,
  input  logic                        rst,
  // sample input
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [15:0]                 raw_sample,
  input  logic [12:0]                 frame_samples,
  // byte output
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_byte,
  output logic                        run_last,
  output logic                        frame_end,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [asfp_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import asfp_pkg::*;

  // configuration register
  logic [4:0]  sample_width;

  // input register
  logic        in_full;
  logic [15:0] in_raw;
  logic [12:0] in_cnt;

  // frame state and the pending byte run
  state_t      state;
  state_t      state_next;
  run_t        run;
  run_t        run_next;
  logic [3:0]  run_left;
  logic [3:0]  run_idx;

  logic        reg_hit;
  logic        out_free;
  logic        out_load;
  logic        run_done;
  logic        in_adv;
  logic        in_take;

  // ---------------------------------------------------------------- APB
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == ADDR_SAMPLE_WIDTH[2]);
  assign prdata  = reg_hit ? {27'd0, sample_width} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_width <= WIDTH_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      sample_width <= pwdata[4:0];
    end
  end

  // ---------------------------------------------------------------- control
  // Output register takes a byte when empty or being drained.
  assign out_free = !out_valid || !out_stall;
  assign out_load = out_free && (run_left != 4'd0);
  // The run buffer frees up this cycle when its last byte moves out.
  assign run_done = (run_left == 4'd0) || ((run_left == 4'd1) && out_load);
  assign in_adv   = in_full && run_done;
  assign in_stall = in_full && !run_done;
  assign in_take  = in_valid && !in_stall;

  asfp_frame_fmt u_fmt (
    .sample_width (sample_width),
    .raw_sample   (in_raw),
    .frame_samples(in_cnt),
    .cur          (state),
    .nxt          (state_next),
    .run          (run_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      state     <= '0;
      run_left  <= 4'd0;
      run_idx   <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      if (in_take) begin
        in_full <= 1'b1;
      end else if (in_adv) begin
        in_full <= 1'b0;
      end

      if (in_adv) begin
        state    <= state_next;
        run_left <= run_next.len;
        run_idx  <= 4'd0;
      end else if (out_load) begin
        run_left <= run_left - 4'd1;
        run_idx  <= run_idx + 4'd1;
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_raw <= raw_sample;
      in_cnt <= frame_samples;
    end
    if (in_adv) begin
      run <= run_next;
    end
    if (out_load) begin
      out_byte  <= run.bytes[run_idx];
      run_last  <= (run_left == 4'd1);
      frame_end <= (run_left == 4'd1) && run.frame_end;
    end
  end

  // ---------------------------------------------------------------- checks
  `ASFP_CHECK(a_run_bound, clk, rst, run_left <= RUN_MAX_LEN, "run length above 13 bytes")
  `ASFP_CHECK(a_end_is_last, clk, rst, (out_valid && frame_end) |-> run_last, "frame end off run end")
  `ASFP_CHECK(a_frame_left, clk, rst, state.in_frame |-> (state.samples_left != 13'd0), "open frame with no samples left")
  `ASFP_CHECK(a_run_drains, clk, rst, (in_adv && (run_next.len != 4'd0)) |=> (run_idx == 4'd0) && (run_left != 4'd0), "new run not loaded")

endmodule
